// File: hw/rtl/cgas_pkg.sv
`timescale 1ns / 1ps

package cgas_pkg;

    localparam int NUM_CLASSES_DEF = 20;
    localparam int MAX_OBJECTS     = 64;
    localparam int TAG_W           = $clog2(MAX_OBJECTS);
    localparam int CLASS_W         = 5;
    localparam int POS_W           = 24;
    localparam int AREA_W          = 26;
    localparam int SCORE_W         = 17;
    localparam int D2_W            = 21;
    localparam int SQ_W            = 52;
    localparam int D2S_W           = SQ_W - 32;
    localparam int ROOT_W          = 26;
    localparam int SQ_STAGES       = 26;

    localparam logic [CLASS_W-1:0] CLS_UNKNOWN    = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_CAR        = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_TRUCK      = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_BUS        = 5'd3;
    localparam logic [CLASS_W-1:0] CLS_BICYCLE    = 5'd4;
    localparam logic [CLASS_W-1:0] CLS_MOTORBIKE  = 5'd5;
    localparam logic [CLASS_W-1:0] CLS_PEDESTRIAN = 5'd6;

    typedef enum logic [1:0] {
        MD_1M,
        MD_2M,
        MD_3M
    } t_maxd;

    typedef struct packed {
        logic              ok;
        t_maxd             maxd;
        logic [AREA_W-1:0] lo;
        logic [AREA_W-1:0] hi;
    } t_rule;

    typedef struct packed {
        logic             pass;
        t_maxd            maxd;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
    } t_side;

    function automatic t_rule f_rule(input logic [CLASS_W-1:0] a,
                                     input logic [CLASS_W-1:0] b,
                                     input logic [CLASS_W:0]   nc);
        t_rule r;
        logic  va, vb, ta, tb;
        r.ok   = 1'b0;
        r.maxd = MD_1M;
        r.lo   = '0;
        r.hi   = '0;
        va = a inside {CLS_CAR, CLS_TRUCK, CLS_BUS};
        vb = b inside {CLS_CAR, CLS_TRUCK, CLS_BUS};
        ta = a inside {CLS_BICYCLE, CLS_MOTORBIKE};
        tb = b inside {CLS_BICYCLE, CLS_MOTORBIKE};
        if ({1'b0, a} < nc && {1'b0, b} < nc) begin
            if (va && vb) begin
                r.ok   = 1'b1;
                r.maxd = MD_3M;
                if (b == CLS_CAR) begin
                    r.lo = 26'd14746;
                    r.hi = 26'd49561;
                end else if (b == CLS_TRUCK) begin
                    r.lo = 26'd24576;
                    r.hi = 26'd80896;
                end else begin
                    r.lo = 26'd40960;
                    r.hi = 26'd132710;
                end
            end else if (ta && tb) begin
                r.ok   = 1'b1;
                r.maxd = MD_2M;
                r.lo   = 26'd5;
                r.hi   = (b == CLS_BICYCLE) ? 26'd10240 : 26'd12288;
            end else if (a == b) begin
                r.ok = 1'b1;
                if (a == CLS_PEDESTRIAN) begin
                    r.maxd = MD_2M;
                    r.lo   = 26'd5;
                    r.hi   = 26'd8192;
                end else if (a == CLS_UNKNOWN) begin
                    r.hi = 26'd102400;
                end else begin
                    r.hi = 26'd40960000;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/cgas_sqrt_pipe.sv
`timescale 1ns / 1ps

module cgas_sqrt_pipe import cgas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [D2S_W-1:0]  i_d2,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_rem_nz,
    output t_side             o_side
);

    logic [SQ_W-1:0] r_x   [SQ_STAGES];
    logic [SQ_W-1:0] r_res [SQ_STAGES];
    logic            r_vld [SQ_STAGES];
    t_side           r_sd  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [SQ_W-1:0] x_in, res_in, bit_k, t;
        logic            v_in;
        t_side           sd_in;
        logic [SQ_W-1:0] n_x, n_res;

        if (k == 0) begin : g_first
            assign x_in   = {i_d2, {(SQ_W-D2S_W){1'b0}}};
            assign res_in = '0;
            assign v_in   = i_valid;
            assign sd_in  = i_side;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
            assign v_in   = r_vld[k-1];
            assign sd_in  = r_sd[k-1];
        end

        assign bit_k = SQ_W'(1) << (SQ_W - 2 - 2*k);
        assign t     = res_in + bit_k;

        always_comb begin
            if (x_in >= t) begin
                n_x   = x_in - t;
                n_res = (res_in >> 1) + bit_k;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
            if (i_en) begin
                r_x[k]   <= n_x;
                r_res[k] <= n_res;
                r_sd[k]  <= sd_in;
            end
        end
    end

    assign o_valid  = r_vld[SQ_STAGES-1];
    assign o_root   = r_res[SQ_STAGES-1][ROOT_W-1:0];
    assign o_rem_nz = |r_x[SQ_STAGES-1];
    assign o_side   = r_sd[SQ_STAGES-1];

endmodule

// File: hw/rtl/class_gated_association_score.sv
`timescale 1ns / 1ps

// class gated distance association score, one candidate pair per beat
// slave channel: pair beat with both classes, positions, areas and matrix tags
// master channel: Q1.16 score with the tags copied through
// score is zero when the class pair is not allowed, the distance exceeds the
// pair's maximum distance or either area lies outside the pair's window
// throughput: one beat per cycle while the output is not stalled; the square
// root is a 26 stage pipeline that yields one result bit per stage
// the whole pipeline advances only when the output register is empty or taken;
// while the receiver stalls o_s_tready is low and nothing is lost or repeated
// reset clears all valid bits; no memory, no clearing pass, no configuration
// every beat gives exactly one result beat, in order

module class_gated_association_score import cgas_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // class_a, class_b, pos_x_a, pos_y_a, pos_x_b, pos_y_b, area_a, area_b,
    // row_tag, col_tag, zero pad
    input  logic [175:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // score, row_out, col_out, zero pad
    output logic [31:0]  o_m_tdata
);

    localparam logic [CLASS_W:0] NC = (CLASS_W+1)'(NUM_CLASSES);

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // field unpack
    logic [CLASS_W-1:0]       cls_a, cls_b;
    logic signed [POS_W-1:0]  pxa, pya, pxb, pyb;
    logic [AREA_W-1:0]        ar_a, ar_b;
    logic [TAG_W-1:0]         tag_r, tag_c;
    assign cls_a = i_s_tdata[4:0];
    assign cls_b = i_s_tdata[9:5];
    assign pxa   = i_s_tdata[33:10];
    assign pya   = i_s_tdata[57:34];
    assign pxb   = i_s_tdata[81:58];
    assign pyb   = i_s_tdata[105:82];
    assign ar_a  = i_s_tdata[131:106];
    assign ar_b  = i_s_tdata[157:132];
    assign tag_r = i_s_tdata[163:158];
    assign tag_c = i_s_tdata[169:164];

    // stage 1: differences, class rule, area window
    t_rule              rule;
    logic signed [24:0] dx, dy;
    logic [24:0]        adx, ady;
    assign rule = f_rule(cls_a, cls_b, NC);
    assign dx   = 25'(pxa) - 25'(pxb);
    assign dy   = 25'(pya) - 25'(pyb);
    assign adx  = dx[24] ? 25'(-dx) : 25'(dx);
    assign ady  = dy[24] ? 25'(-dy) : 25'(dy);

    logic        r_s1_valid, r_s1_ok, r_s1_far;
    t_maxd       r_s1_maxd;
    logic [9:0]  r_s1_adx, r_s1_ady;
    logic [TAG_W-1:0] r_s1_row, r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_s_tvalid;
        end
        if (en) begin
            r_s1_ok   <= rule.ok && ar_a >= rule.lo && ar_a <= rule.hi
                         && ar_b >= rule.lo && ar_b <= rule.hi;
            r_s1_far  <= adx > 25'd768 || ady > 25'd768;
            r_s1_maxd <= rule.maxd;
            r_s1_adx  <= adx[9:0];
            r_s1_ady  <= ady[9:0];
            r_s1_row  <= tag_r;
            r_s1_col  <= tag_c;
        end
    end

    // stage 2: squared distance and gate
    logic [D2_W-1:0] d2;
    logic [D2_W-1:0] m2;
    assign d2 = D2_W'(r_s1_adx * r_s1_adx) + D2_W'(r_s1_ady * r_s1_ady);
    always_comb begin
        case (r_s1_maxd)
            MD_1M:   m2 = D2_W'(65536);
            MD_2M:   m2 = D2_W'(262144);
            MD_3M:   m2 = D2_W'(589824);
            default: m2 = '0;
        endcase
    end

    logic            r_s2_valid;
    logic [D2_W-1:0] r_s2_d2;
    t_side           r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en) begin
            r_s2_d2        <= d2;
            r_s2_side.pass <= r_s1_ok && !r_s1_far && d2 <= m2;
            r_s2_side.maxd <= r_s1_maxd;
            r_s2_side.row  <= r_s1_row;
            r_s2_side.col  <= r_s1_col;
        end
    end

    // square root of d2 * 2^32; a passing pair keeps d2 below 2^20
    logic              sq_valid, sq_rem_nz;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    cgas_sqrt_pipe u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s2_valid),
        .i_d2     (r_s2_d2[D2S_W-1:0]),
        .i_side   (r_s2_side),
        .o_valid  (sq_valid),
        .o_root   (sq_root),
        .o_rem_nz (sq_rem_nz),
        .o_side   (sq_side)
    );

    // p1: ceiling root
    logic              r_p1_valid;
    logic [ROOT_W-1:0] r_p1_root;
    t_side             r_p1_side;

    // p2: ceil by 256 or 512, prepared operand for divide by 3
    logic              r_p2_valid;
    logic [18:0]       r_p2_qsh;
    logic [18:0]       r_p2_n3;
    t_side             r_p2_side;

    // p3: reciprocal multiply
    logic              r_p3_valid;
    logic [18:0]       r_p3_qsh;
    logic [36:0]       r_p3_prod;
    t_side             r_p3_side;

    logic [18:0] q256, q512;
    assign q256 = 19'(r_p1_root[25:8]) + 19'(|r_p1_root[7:0]);
    assign q512 = 19'(r_p1_root[25:9]) + 19'(|r_p1_root[8:0]);

    logic [18:0] q;
    assign q = (r_p3_side.maxd == MD_3M) ? 19'(r_p3_prod[36:19]) : r_p3_qsh;

    logic             r_o_valid;
    logic [SCORE_W-1:0] r_o_score;
    logic [TAG_W-1:0] r_o_row, r_o_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_p1_valid <= sq_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_o_valid  <= r_p3_valid;
        end
        if (en) begin
            r_p1_root <= sq_root + ROOT_W'(sq_rem_nz);
            r_p1_side <= sq_side;

            r_p2_qsh  <= (r_p1_side.maxd == MD_2M) ? q512 : q256;
            r_p2_n3   <= q256 + 19'd2;
            r_p2_side <= r_p1_side;

            r_p3_qsh  <= r_p2_qsh;
            r_p3_prod <= r_p2_n3 * 18'd174763;
            r_p3_side <= r_p2_side;

            r_o_score <= r_p3_side.pass ? (SCORE_W'(65536) - q[SCORE_W-1:0]) : '0;
            r_o_row   <= r_p3_side.row;
            r_o_col   <= r_p3_side.col;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'b0, r_o_col, r_o_row, r_o_score};

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_o_score <= SCORE_W'(65536))
        else $error("score above one");

    a_class_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s1_valid && !r_s1_ok |=> !r_s2_side.pass)
        else $error("rejected pair passed the gate");

    a_coincident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s1_valid && r_s1_ok && r_s1_adx == 10'd0 && r_s1_ady == 10'd0
        && !r_s1_far |=> r_s2_side.pass && r_s2_d2 == '0)
        else $error("coincident allowed pair rejected");

endmodule
